/* sv/dpid_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package dpid_pkg;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [31:0] goal_x;
		logic signed [31:0] goal_y;
		logic [31:0]        delta_time;
	} item_t;

	typedef struct packed {
		logic signed [31:0] kp_linear;
		logic signed [31:0] ki_linear;
		logic signed [31:0] kd_linear;
		logic signed [31:0] kp_angular;
		logic signed [31:0] ki_angular;
		logic signed [31:0] kd_angular;
		logic [47:0]        linear_limits;
		logic [48:0]        angular_limits_mode;
	} cfg_t;

	typedef enum logic [3:0] {
		REG_KP_LIN,
		REG_KI_LIN,
		REG_KD_LIN,
		REG_KP_ANG,
		REG_KI_ANG,
		REG_KD_ANG,
		REG_LIN_LIM,
		REG_ANG_LIM
	} cfg_reg_t;

	localparam logic [47:0] LIN_LIM_RST = 48'd241893965824;
	localparam logic [48:0] ANG_LIM_RST = 49'd3122609258496;
	localparam logic signed [31:0] GAIN_ONE = 32'sd65536;

	localparam logic signed [35:0] PI_Q29      = 36'sd1686629713;
	localparam logic signed [35:0] HALF_PI_Q29 = 36'sd843314856;
	localparam logic signed [35:0] TWO_PI_Q29  = 36'sd3373259426;

	typedef logic [31:0] atan_tab_t [32];

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// shift-subtract division, elaboration only
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// atan(2^-i) in Q29 from its power series in Q62
	function automatic logic [31:0] atan_q29(input int i);
		logic [63:0] sum;
		logic [63:0] t;
		int p;
		sum = '0;
		if (i == 0) return 32'd421657428;
		for (int k = 0; k < 32; k++) begin
			if ((2 * k + 1) * i <= 61) begin
				p = 62 - (2 * k + 1) * i;
				t = udiv64(64'd1 << p, 64'(2 * k + 1));
				if ((k & 1) != 0) sum = sum - t;
				else sum = sum + t;
			end
		end
		return 32'((sum + (64'd1 << 32)) >> 33);
	endfunction

	function automatic atan_tab_t build_atan();
		atan_tab_t tab;
		for (int i = 0; i < 32; i++) tab[i] = atan_q29(i);
		return tab;
	endfunction

	localparam atan_tab_t ATAN_TAB = build_atan();

endpackage
`default_nettype wire

/* sv/dpid_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module dpid_queue import dpid_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  wr,
	input  wire item_t wdata,
	output logic       full,
	input  wire logic  rd,
	output item_t      rdata,
	output logic       empty
);

	item_t       mem_q [2];
	logic        wp_q;
	logic        rp_q;
	logic [1:0]  cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* sv/dpid_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module dpid_front import dpid_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire item_t       item,
	input  wire logic        q_full,
	output logic             q_wr,
	output item_t            q_wdata,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [3:0]  cfg_index,
	input  wire logic [48:0] cfg_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	assign full      = q_full;
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;
	assign q_wdata   = item;
	// a tick with no elapsed time is taken and dropped
	assign q_wr      = push && !q_full && (item.delta_time != 32'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp_linear           <= GAIN_ONE;
			cfg_q.ki_linear           <= '0;
			cfg_q.kd_linear           <= '0;
			cfg_q.kp_angular          <= GAIN_ONE;
			cfg_q.ki_angular          <= '0;
			cfg_q.kd_angular          <= '0;
			cfg_q.linear_limits       <= LIN_LIM_RST;
			cfg_q.angular_limits_mode <= ANG_LIM_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_KP_LIN:  cfg_q.kp_linear           <= cfg_data[31:0];
				REG_KI_LIN:  cfg_q.ki_linear           <= cfg_data[31:0];
				REG_KD_LIN:  cfg_q.kd_linear           <= cfg_data[31:0];
				REG_KP_ANG:  cfg_q.kp_angular          <= cfg_data[31:0];
				REG_KI_ANG:  cfg_q.ki_angular          <= cfg_data[31:0];
				REG_KD_ANG:  cfg_q.kd_angular          <= cfg_data[31:0];
				REG_LIN_LIM: cfg_q.linear_limits       <= cfg_data[47:0];
				REG_ANG_LIM: cfg_q.angular_limits_mode <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

/* sv/dpid_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module dpid_back import dpid_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_empty,
	input  wire item_t       q_item,
	output logic             q_pop,
	input  wire cfg_t        cfg,
	input  wire logic        pop,
	output logic             empty,
	output logic signed [31:0] linear_velocity,
	output logic signed [31:0] angular_velocity,
	output logic             reversed
);

	localparam logic [5:0] CORD_LAST = 6'(CORDIC_STEPS - 1);
	localparam logic [5:0] DIV_LAST  = 6'd48;
	localparam logic [5:0] SQRT_LAST = 6'd31;

	typedef enum logic [4:0] {
		S_IDLE, S_SQX, S_SQY, S_QWZ, S_QXY, S_QYY, S_QZZ, S_CYC, S_SQRT,
		S_CINIT, S_CORD, S_ERR, S_PK, S_PI, S_PINT, S_DIV, S_DEND, S_PD,
		S_LA, S_LB, S_LC, S_OUT
	} state_t;

	state_t state_q;
	item_t  itm_q;
	logic [5:0] cnt_q;

	logic signed [32:0] dx_q, dy_q;
	logic [63:0] rad_q, sr_q, sb_q;
	logic signed [31:0] t_q;
	logic signed [33:0] sy_q, cy_q;
	logic signed [31:0] dist_q;
	logic signed [51:0] crx_q, cry_q;
	logic signed [33:0] crz_q, zh_q;
	logic csel_q, asel_q, rev_q;
	logic signed [31:0] eh_q, p_q, ul_q;
	logic [31:0] dv_rem_q;
	logic [48:0] dv_quo_q;
	logic dv_neg_q;
	logic signed [31:0] last_de_q, dint_q, last_he_q, hint_q, last_lc_q, last_ac_q;
	logic out_valid_q;
	logic signed [31:0] lv_q, av_q;
	logic rv_q;

	logic signed [65:0] prod_q;
	logic signed [32:0] ma, mb;

	// shared multiplier, one product per cycle
	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
	end

	logic signed [32:0] ax, ay;
	logic signed [49:0] mq_w;
	logic signed [31:0] mq, pq32;
	assign ax   = dx_q[32] ? -dx_q : dx_q;
	assign ay   = dy_q[32] ? -dy_q : dy_q;
	assign mq_w = prod_q[65:16];
	assign mq   = sat32(64'(mq_w));
	assign pq32 = prod_q[31:0];

	// pid operand selection
	logic signed [31:0] perr, plast, pinteg, kp, ki, kd;
	assign perr   = asel_q ? eh_q : dist_q;
	assign plast  = asel_q ? last_he_q : last_de_q;
	assign pinteg = asel_q ? hint_q : dint_q;
	assign kp     = asel_q ? cfg.kp_angular : cfg.kp_linear;
	assign ki     = asel_q ? cfg.ki_angular : cfg.ki_linear;
	assign kd     = asel_q ? cfg.kd_angular : cfg.kd_linear;

	logic signed [49:0] rate_w;
	logic signed [31:0] rate_sat;
	assign rate_w   = dv_neg_q ? -signed'({1'b0, dv_quo_q}) : signed'({1'b0, dv_quo_q});
	assign rate_sat = sat32(64'(rate_w));

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			S_SQX: begin ma = {1'b0, ax[31:0]}; mb = {1'b0, ax[31:0]}; end
			S_SQY: begin ma = {1'b0, ay[31:0]}; mb = {1'b0, ay[31:0]}; end
			S_QWZ: begin ma = 33'(itm_q.quat_w); mb = 33'(itm_q.quat_z); end
			S_QXY: begin ma = 33'(itm_q.quat_x); mb = 33'(itm_q.quat_y); end
			S_QYY: begin ma = 33'(itm_q.quat_y); mb = 33'(itm_q.quat_y); end
			S_QZZ: begin ma = 33'(itm_q.quat_z); mb = 33'(itm_q.quat_z); end
			S_PK:  begin ma = 33'(kp); mb = 33'(perr); end
			S_PI:  begin ma = 33'(ki); mb = 33'(perr); end
			S_DEND: begin ma = 33'(kd); mb = 33'(rate_sat); end
			S_LA:  begin
				ma = {9'b0, cfg.linear_limits[23:0]};
				mb = {1'b0, itm_q.delta_time};
			end
			S_LB:  begin
				ma = {9'b0, cfg.angular_limits_mode[23:0]};
				mb = {1'b0, itm_q.delta_time};
			end
			default: ;
		endcase
	end

	// square root step
	logic [63:0] sq_sum, r_next, rad_next;
	logic        sq_big;
	always_comb begin
		sq_sum = sr_q + sb_q;
		if (rad_q >= sq_sum) begin
			rad_next = rad_q - sq_sum;
			r_next   = (sr_q >> 1) + sb_q;
		end else begin
			rad_next = rad_q;
			r_next   = sr_q >> 1;
		end
	end
	assign sq_big = ax[32] | ax[31] | ay[32] | ay[31];

	// cordic start and step
	logic signed [33:0] cin_x, cin_y;
	logic signed [51:0] xs0, ys0, crx_sh, cry_sh, crx_n, cry_n;
	logic signed [33:0] atan_v, crz_n;
	assign cin_x  = csel_q ? cy_q : 34'(dx_q);
	assign cin_y  = csel_q ? sy_q : 34'(dy_q);
	assign xs0    = {{2{cin_x[33]}}, cin_x, 16'b0};
	assign ys0    = {{2{cin_y[33]}}, cin_y, 16'b0};
	assign crx_sh = crx_q >>> cnt_q[4:0];
	assign cry_sh = cry_q >>> cnt_q[4:0];
	assign atan_v = signed'({2'b0, ATAN_TAB[cnt_q[4:0]]});
	always_comb begin
		if (!cry_q[51]) begin
			crx_n = crx_q + cry_sh;
			cry_n = cry_q - crx_sh;
			crz_n = crz_q + atan_v;
		end else begin
			crx_n = crx_q - cry_sh;
			cry_n = cry_q + crx_sh;
			crz_n = crz_q - atan_v;
		end
	end

	// heading error wrap and reverse fold
	logic signed [35:0] e0, e1, e2;
	logic               fold;
	always_comb begin
		e0 = 36'(zh_q) - 36'(crz_q);
		if (e0 > PI_Q29) e1 = e0 - TWO_PI_Q29;
		else if (e0 < -PI_Q29) e1 = e0 + TWO_PI_Q29;
		else e1 = e0;
		e2   = e1;
		fold = 1'b0;
		if (cfg.angular_limits_mode[48]) begin
			if (e1 > HALF_PI_Q29) begin
				e2   = e1 - PI_Q29;
				fold = 1'b1;
			end else if (e1 < -HALF_PI_Q29) begin
				e2   = e1 + PI_Q29;
				fold = 1'b1;
			end
		end
	end

	// divider step, remainder stays below delta_time
	logic [32:0] dv_sh;
	logic        dv_ge;
	logic signed [32:0] dnum, dmag;
	assign dv_sh = {dv_rem_q, dv_quo_q[48]};
	assign dv_ge = dv_sh >= {1'b0, itm_q.delta_time};
	assign dnum  = 33'(perr) - 33'(plast);
	assign dmag  = dnum[32] ? -dnum : dnum;

	logic signed [31:0] integ_n, pid_u;
	assign integ_n = sat32(64'(pinteg) + 64'(mq));
	assign pid_u   = sat32(64'(p_q) + 64'(pinteg) + 64'(mq));

	function automatic logic signed [31:0] limit_cmd(input logic signed [31:0] u,
			input logic signed [31:0] last, input logic [39:0] lim,
			input logic [23:0] vmax);
		logic signed [41:0] step, l, v, vm;
		step = 42'(u) - 42'(last);
		l    = signed'({2'b0, lim});
		vm   = signed'({18'b0, vmax});
		if (step > l) step = l;
		if (step < -l) step = -l;
		v = 42'(last) + step;
		if (v > vm) v = vm;
		if (v < -vm) v = -vm;
		return v[31:0];
	endfunction

	logic out_load;
	assign q_pop    = (state_q == S_IDLE) && !q_empty;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || pop);

	assign empty            = !out_valid_q;
	assign linear_velocity  = lv_q;
	assign angular_velocity = av_q;
	assign reversed         = rv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			itm_q       <= '0;
			cnt_q       <= '0;
			dx_q        <= '0;
			dy_q        <= '0;
			rad_q       <= '0;
			sr_q        <= '0;
			sb_q        <= '0;
			t_q         <= '0;
			sy_q        <= '0;
			cy_q        <= '0;
			dist_q      <= '0;
			crx_q       <= '0;
			cry_q       <= '0;
			crz_q       <= '0;
			zh_q        <= '0;
			csel_q      <= 1'b0;
			asel_q      <= 1'b0;
			rev_q       <= 1'b0;
			eh_q        <= '0;
			p_q         <= '0;
			ul_q        <= '0;
			dv_rem_q    <= '0;
			dv_quo_q    <= '0;
			dv_neg_q    <= 1'b0;
			last_de_q   <= '0;
			dint_q      <= '0;
			last_he_q   <= '0;
			hint_q      <= '0;
			last_lc_q   <= '0;
			last_ac_q   <= '0;
			out_valid_q <= 1'b0;
			lv_q        <= '0;
			av_q        <= '0;
			rv_q        <= 1'b0;
		end else begin
			if (pop && !out_load) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						itm_q   <= q_item;
						dx_q    <= 33'(q_item.goal_x) - 33'(q_item.pos_x);
						dy_q    <= 33'(q_item.goal_y) - 33'(q_item.pos_y);
						csel_q  <= 1'b0;
						asel_q  <= 1'b0;
						state_q <= S_SQX;
					end
				end
				S_SQX: state_q <= S_SQY;
				S_SQY: begin
					rad_q   <= prod_q[63:0];
					state_q <= S_QWZ;
				end
				S_QWZ: begin
					rad_q   <= rad_q + prod_q[63:0];
					state_q <= S_QXY;
				end
				S_QXY: begin
					t_q     <= pq32;
					state_q <= S_QYY;
				end
				S_QYY: begin
					sy_q    <= (34'(t_q) + 34'(pq32)) <<< 1;
					state_q <= S_QZZ;
				end
				S_QZZ: begin
					t_q     <= pq32;
					state_q <= S_CYC;
				end
				S_CYC: begin
					cy_q    <= 34'sd268435456 - ((34'(t_q) + 34'(pq32)) <<< 1);
					sr_q    <= '0;
					sb_q    <= 64'h4000_0000_0000_0000;
					cnt_q   <= '0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					rad_q <= rad_next;
					sr_q  <= r_next;
					sb_q  <= sb_q >> 2;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == SQRT_LAST) begin
						if (sq_big || r_next > 64'd2147483647) dist_q <= 32'sh7fffffff;
						else dist_q <= r_next[31:0];
						state_q <= S_CINIT;
					end
				end
				S_CINIT: begin
					cnt_q <= '0;
					if (cin_x == 34'sd0 && cin_y == 34'sd0) begin
						// null vector gives angle zero
						if (!csel_q) begin
							zh_q   <= '0;
							csel_q <= 1'b1;
						end else begin
							crz_q   <= '0;
							state_q <= S_ERR;
						end
					end else begin
						if (cin_x[33]) begin
							crx_q <= -xs0;
							cry_q <= -ys0;
							crz_q <= cin_y[33] ? -34'(PI_Q29) : 34'(PI_Q29);
						end else begin
							crx_q <= xs0;
							cry_q <= ys0;
							crz_q <= '0;
						end
						state_q <= S_CORD;
					end
				end
				S_CORD: begin
					crx_q <= crx_n;
					cry_q <= cry_n;
					crz_q <= crz_n;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == CORD_LAST) begin
						if (!csel_q) begin
							zh_q    <= crz_n;
							csel_q  <= 1'b1;
							state_q <= S_CINIT;
						end else begin
							state_q <= S_ERR;
						end
					end
				end
				S_ERR: begin
					eh_q    <= sat32(64'(e2 >>> 13));
					rev_q   <= fold;
					asel_q  <= 1'b0;
					state_q <= S_PK;
				end
				S_PK: state_q <= S_PI;
				S_PI: begin
					p_q     <= mq;
					state_q <= S_PINT;
				end
				S_PINT: begin
					if (asel_q) hint_q <= integ_n;
					else dint_q <= integ_n;
					dv_quo_q <= {dmag, 16'b0};
					dv_rem_q <= '0;
					dv_neg_q <= dnum[32];
					cnt_q    <= '0;
					state_q  <= S_DIV;
				end
				S_DIV: begin
					if (dv_ge) dv_rem_q <= 32'(dv_sh - {1'b0, itm_q.delta_time});
					else dv_rem_q <= dv_sh[31:0];
					dv_quo_q <= {dv_quo_q[47:0], dv_ge};
					cnt_q    <= cnt_q + 6'd1;
					if (cnt_q == DIV_LAST) state_q <= S_DEND;
				end
				S_DEND: begin
					if (asel_q) last_he_q <= perr;
					else last_de_q <= perr;
					state_q <= S_PD;
				end
				S_PD: begin
					if (!asel_q) begin
						ul_q    <= rev_q ? sat32(-64'(pid_u)) : pid_u;
						asel_q  <= 1'b1;
						state_q <= S_PK;
					end else begin
						p_q     <= pid_u;
						state_q <= S_LA;
					end
				end
				S_LA: state_q <= S_LB;
				S_LB: begin
					last_lc_q <= limit_cmd(ul_q, last_lc_q, prod_q[55:16],
						cfg.linear_limits[47:24]);
					state_q   <= S_LC;
				end
				S_LC: begin
					last_ac_q <= limit_cmd(p_q, last_ac_q, prod_q[55:16],
						cfg.angular_limits_mode[47:24]);
					state_q   <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						lv_q        <= last_lc_q;
						av_q        <= last_ac_q;
						rv_q        <= rev_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_pop_once: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> !q_pop)
		else $error("queue popped twice for one request");

	a_cord_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CORD) |-> (cnt_q < 6'(CORDIC_STEPS)))
		else $error("cordic ran past its last step");

	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (cnt_q <= DIV_LAST))
		else $error("divider ran past its last step");

	a_lin_lim: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LC) |-> ((33'(last_lc_q) <= signed'({9'b0, cfg.linear_limits[47:24]}))
			&& (33'(last_lc_q) >= -signed'({9'b0, cfg.linear_limits[47:24]}))))
		else $error("linear command beyond velocity limit");

endmodule
`default_nettype wire

/* sv/dual_pid_heading_drive_controller.sv */
`timescale 1ns / 1ps
`default_nettype none
// the single back-end sequencer finishes one request before it takes the next, sharing one
//   multiplier, the square root, the cordic and the 1-bit divider
// a request with zero delta_time is taken and gives no result
// reset (arst_n low, asynchronous) clears loop state, the queue and restores register defaults
module dual_pid_heading_drive_controller import dpid_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [15:0] quat_w,
	input  wire logic signed [15:0] quat_x,
	input  wire logic signed [15:0] quat_y,
	input  wire logic signed [15:0] quat_z,
	input  wire logic signed [31:0] goal_x,
	input  wire logic signed [31:0] goal_y,
	input  wire logic [31:0]        delta_time,
	output logic                    empty,
	input  wire logic               pop,
	output logic signed [31:0]      linear_velocity,
	output logic signed [31:0]      angular_velocity,
	output logic                    reversed,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [3:0]         cfg_index,
	input  wire logic [48:0]        cfg_data
);

	item_t item;
	item_t q_wdata;
	item_t q_rdata;
	cfg_t  cfg;
	logic  q_wr, q_full, q_rd, q_empty;

	assign item = '{pos_x: pos_x, pos_y: pos_y, quat_w: quat_w, quat_x: quat_x,
		quat_y: quat_y, quat_z: quat_z, goal_x: goal_x, goal_y: goal_y,
		delta_time: delta_time};

	dpid_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.q_full    (q_full),
		.q_wr      (q_wr),
		.q_wdata   (q_wdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dpid_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.full   (q_full),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	dpid_back #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_empty          (q_empty),
		.q_item           (q_rdata),
		.q_pop            (q_rd),
		.cfg              (cfg),
		.pop              (pop),
		.empty            (empty),
		.linear_velocity  (linear_velocity),
		.angular_velocity (angular_velocity),
		.reversed         (reversed)
	);

endmodule
`default_nettype wire
